FILE: src/plf_pkg.sv
// Shared types and constants for the path lookahead point finder.
// Used by every module of the block but plf_ram; depends on nothing else.
`timescale 1ns / 1ps

package plf_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W = 24;
    localparam int HEAD_W  = 16;
    localparam int SPD_W   = 16;
    localparam int LA_W    = 24;
    localparam int PIDX_W  = 32;
    localparam int CUM_W   = 36;
    localparam int NUM_W   = 10;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int ROOT_W  = (DIST_W + 1) / 2;
    localparam int TGT_W   = CUM_W + 1;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_FETCH  = 2'd3
    } mode_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [HEAD_W-1:0]  heading;
        logic [SPD_W-1:0]          speed;
        logic [CUM_W-1:0]          cum;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Status and result of the distance pipeline.
    typedef struct packed {
        logic              busy;
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [CUM_W-1:0]  cum;
        logic [DIST_W-1:0] sqd;
    } dist_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_AP_WR,
        ST_TGT,
        ST_SEARCH,
        ST_SEL,
        ST_EMIT,
        ST_EMPTY,
        ST_MOD_GO,
        ST_MOD_WAIT
    } state_t;

endpackage

FILE: src/path_lookahead_point_finder_top.sv
// Lookahead waypoint finder: control sequencer, point memory and output register.
// Depends on plf_pkg, plf_ram, plf_dist, plf_isqrt and plf_mod.
`timescale 1ns / 1ps

// Holds up to MAX_POINTS waypoints in one memory (position, heading, speed and
// cumulative distance per entry) and takes one word at a time. An append to a
// non-empty path runs the last stored point through the distance pipeline and
// then a square root. A lookahead query streams every stored point through the
// distance pipeline, one memory read per cycle, then streams cumulative
// distances until the target is reached. A fetch by index runs a remainder
// unit. Queries and fetches return one word each; appends and clears return
// none. The result sits in an output register, so the next word is taken while
// it waits. No memory clearing pass follows reset.
module path_lookahead_point_finder_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: pos_x, pos_y, heading, target_speed, lookahead_dist, point_index
    input  logic [135:0] s_tdata,
    // s_tuser: mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: point_x, point_y, point_heading, point_speed, point_number, zero pad
    output logic [95:0]  m_tdata,
    // m_tuser: path_empty
    output logic [0:0]   m_tuser
);
    import plf_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg;
    logic [CUM_W-1:0] total_reg;
    mode_t mode_reg;
    logic signed [COORD_W-1:0] qx_reg, qy_reg;
    logic signed [HEAD_W-1:0] h_reg;
    logic [SPD_W-1:0] spd_reg;
    logic [LA_W-1:0] la_reg;
    logic signed [PIDX_W-1:0] pidx_reg;

    logic [CNT_W-1:0] issue_reg;
    logic rd_v_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic best_v_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [CUM_W-1:0] best_cum_reg;
    logic [DIST_W-1:0] d_reg;
    logic [CUM_W-1:0] prev_cum_reg;
    logic [TGT_W-1:0] target_reg;
    logic found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] sel_reg;

    logic m_v_reg;
    logic [95:0] m_data_reg;
    logic m_empty_reg;

    logic accept, issue_go, hit_now, scan_done, search_done, out_free;
    logic ram_we, sq_start, sq_done, mod_start, mod_done;
    logic [IDX_W-1:0] raddr, mod_w;
    logic [ENTRY_W-1:0] rdata_vec;
    entry_t rd_entry, wr_entry;
    dist_res_t dres;
    logic [ROOT_W-1:0] root;
    logic [TGT_W-1:0] cum_sum, tgt_sum;
    logic [CUM_W-1:0] cum_new;
    mode_t s_mode;

    assign s_mode   = mode_t'(s_tuser);
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_v_reg | m_tready;
    assign rd_entry = entry_t'(rdata_vec);

    assign hit_now     = rd_v_reg && !found_reg && ({1'b0, rd_entry.cum} >= target_reg);
    assign scan_done   = (issue_reg == cnt_reg) && !rd_v_reg && !dres.busy;
    assign search_done = (found_reg || issue_reg == cnt_reg) && !rd_v_reg;

    assign cum_sum = {1'b0, prev_cum_reg} + TGT_W'(root);
    assign cum_new = (cnt_reg == '0) ? '0
                   : (cum_sum[CUM_W] ? {CUM_W{1'b1}} : cum_sum[CUM_W-1:0]);
    assign tgt_sum = {1'b0, best_cum_reg} + TGT_W'(la_reg);

    assign wr_entry.x       = qx_reg;
    assign wr_entry.y       = qy_reg;
    assign wr_entry.heading = h_reg;
    assign wr_entry.speed   = spd_reg;
    assign wr_entry.cum     = cum_new;

    plf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .raddr (raddr),
        .rdata (rdata_vec)
    );

    plf_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_v_reg && state_reg == ST_SCAN),
        .in_idx   (rd_idx_reg),
        .in_entry (rd_entry),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .res      (dres)
    );

    plf_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .value   (d_reg),
        .done    (sq_done),
        .root    (root)
    );

    plf_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .index   (pidx_reg),
        .count   (cnt_reg),
        .done    (mod_done),
        .wrapped (mod_w)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        MODE_APPEND: begin
                            if (cnt_reg >= CNT_W'(MAX_POINTS)) begin
                                state_next = ST_IDLE;
                            end else if (cnt_reg == '0) begin
                                state_next = ST_AP_WR;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        MODE_CLEAR: state_next = ST_IDLE;
                        MODE_QUERY: state_next = (cnt_reg == '0) ? ST_EMPTY : ST_SCAN;
                        MODE_FETCH: state_next = (cnt_reg == '0) ? ST_EMPTY : ST_MOD_GO;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = (mode_reg == MODE_APPEND) ? ST_SQ_GO : ST_TGT;
                end
            end
            ST_SQ_GO:    state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:  if (sq_done) state_next = ST_AP_WR;
            ST_AP_WR:    state_next = ST_IDLE;
            ST_TGT:      state_next = ST_SEARCH;
            ST_SEARCH:   if (search_done) state_next = ST_SEL;
            ST_SEL:      state_next = ST_EMIT;
            ST_EMIT:     if (out_free) state_next = ST_IDLE;
            ST_EMPTY:    if (out_free) state_next = ST_IDLE;
            ST_MOD_GO:   state_next = ST_MOD_WAIT;
            ST_MOD_WAIT: if (mod_done) state_next = ST_SEL;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        sq_start  = 1'b0;
        mod_start = 1'b0;
        issue_go  = 1'b0;
        raddr     = sel_reg;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SCAN: begin
                issue_go = issue_reg < cnt_reg;
                raddr    = issue_reg[IDX_W-1:0];
            end
            ST_SEARCH: begin
                issue_go = (issue_reg < cnt_reg) && !found_reg && !hit_now;
                raddr    = issue_reg[IDX_W-1:0];
            end
            ST_SQ_GO:  sq_start  = 1'b1;
            ST_MOD_GO: mod_start = 1'b1;
            ST_AP_WR:  ram_we    = 1'b1;
            default:   raddr     = sel_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            total_reg <= '0;
            rd_v_reg  <= 1'b0;
            m_v_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg  <= issue_go;
            if (accept && s_mode == MODE_CLEAR) begin
                cnt_reg   <= '0;
                total_reg <= '0;
            end
            if (state_reg == ST_AP_WR) begin
                cnt_reg   <= cnt_reg + 1'b1;
                total_reg <= cum_new;
            end
            if ((state_reg == ST_EMIT || state_reg == ST_EMPTY) && out_free) begin
                m_v_reg <= 1'b1;
            end else if (m_tready) begin
                m_v_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg   <= s_mode;
            qx_reg     <= s_tdata[23:0];
            qy_reg     <= s_tdata[47:24];
            h_reg      <= s_tdata[63:48];
            spd_reg    <= s_tdata[79:64];
            la_reg     <= s_tdata[103:80];
            pidx_reg   <= s_tdata[135:104];
            // An append only needs the previous point through the pipeline.
            issue_reg  <= (s_mode == MODE_APPEND) ? cnt_reg - 1'b1 : '0;
            best_v_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else if (issue_go) begin
            issue_reg <= issue_reg + 1'b1;
        end else if (state_reg == ST_TGT) begin
            issue_reg <= '0;
        end
        rd_idx_reg <= issue_reg[IDX_W-1:0];

        if (state_reg == ST_SCAN && dres.valid) begin
            d_reg        <= dres.sqd;
            prev_cum_reg <= dres.cum;
            // Strict compare keeps the lowest index among equal distances.
            if (!best_v_reg || dres.sqd < best_dist_reg) begin
                best_v_reg    <= 1'b1;
                best_dist_reg <= dres.sqd;
                best_cum_reg  <= dres.cum;
            end
        end

        if (state_reg == ST_TGT) begin
            if (total_reg != '0 && tgt_sum > {1'b0, total_reg}) begin
                target_reg <= tgt_sum - {1'b0, total_reg};
            end else begin
                target_reg <= tgt_sum;
            end
        end

        if (state_reg == ST_SEARCH && hit_now) begin
            found_reg   <= 1'b1;
            hit_idx_reg <= rd_idx_reg;
        end

        if (state_reg == ST_SEARCH && search_done) begin
            sel_reg <= found_reg ? hit_idx_reg : IDX_W'(cnt_reg - 1'b1);
        end else if (state_reg == ST_MOD_WAIT && mod_done) begin
            sel_reg <= mod_w;
        end

        if (state_reg == ST_EMIT && out_free) begin
            m_data_reg  <= {6'd0, NUM_W'(sel_reg), rd_entry.speed, rd_entry.heading,
                            rd_entry.y, rd_entry.x};
            m_empty_reg <= 1'b0;
        end else if (state_reg == ST_EMPTY && out_free) begin
            m_data_reg  <= '0;
            m_empty_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_empty_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count exceeds capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == MODE_APPEND && cnt_reg == CNT_W'(MAX_POINTS))
        |=> cnt_reg == CNT_W'(MAX_POINTS))
        else $error("append on a full path changed the count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == MODE_CLEAR) |=> (cnt_reg == '0 && total_reg == '0))
        else $error("clear did not empty the path");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tdata == '0)
        else $error("empty-path word carries nonzero data");
`endif

endmodule

FILE: src/plf_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no package dependency.
`timescale 1ns / 1ps

module plf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/plf_dist.sv
// Three-stage squared-distance pipeline from a stored point to the query position.
// Depends on plf_pkg.
`timescale 1ns / 1ps

module plf_dist (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    input  logic [plf_pkg::IDX_W-1:0]          in_idx,
    input  plf_pkg::entry_t                    in_entry,
    input  logic signed [plf_pkg::COORD_W-1:0] qx,
    input  logic signed [plf_pkg::COORD_W-1:0] qy,
    output plf_pkg::dist_res_t                 res
);
    import plf_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0] i1_reg, i2_reg, i3_reg;
    logic [CUM_W-1:0] c1_reg, c2_reg, c3_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0] sx_reg, sy_reg;
    logic [DIST_W-1:0] d_reg;
    logic signed [SQ_W-1:0] px, py;

    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        i1_reg <= in_idx;
        c1_reg <= in_entry.cum;
        dx_reg <= {in_entry.x[COORD_W-1], in_entry.x} - {qx[COORD_W-1], qx};
        dy_reg <= {in_entry.y[COORD_W-1], in_entry.y} - {qy[COORD_W-1], qy};
        i2_reg <= i1_reg;
        c2_reg <= c1_reg;
        sx_reg <= unsigned'(px);
        sy_reg <= unsigned'(py);
        i3_reg <= i2_reg;
        c3_reg <= c2_reg;
        d_reg  <= {1'b0, sx_reg} + {1'b0, sy_reg};
    end

    assign res.busy  = v1_reg | v2_reg | v3_reg;
    assign res.valid = v3_reg;
    assign res.idx   = i3_reg;
    assign res.cum   = c3_reg;
    assign res.sqd   = d_reg;

endmodule

FILE: src/plf_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on plf_pkg.
`timescale 1ns / 1ps

module plf_isqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [plf_pkg::DIST_W-1:0]   value,
    output logic                         done,
    output logic [plf_pkg::ROOT_W-1:0]   root
);
    import plf_pkg::*;

    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int STEP_W = $clog2(ROOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PAD_W-1:0]  v_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_sh, trial;

    assign rem_sh = {rem_reg[REM_W-3:0], v_reg[PAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == STEP_W'(ROOT_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (start) begin
            step_reg <= '0;
            v_reg    <= PAD_W'(value);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            v_reg    <= {v_reg[PAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: src/plf_mod.sv
// Restoring remainder unit: wraps a signed index into 0..count-1, one bit per cycle.
// Depends on plf_pkg.
`timescale 1ns / 1ps

module plf_mod (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [plf_pkg::PIDX_W-1:0] index,
    input  logic [plf_pkg::CNT_W-1:0]         count,
    output logic                              done,
    output logic [plf_pkg::IDX_W-1:0]         wrapped
);
    import plf_pkg::*;

    localparam int MAG_W  = PIDX_W + 1;
    localparam int STEP_W = $clog2(MAG_W);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [MAG_W-1:0]  q_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W:0]    t;
    logic [CNT_W-1:0]  w;

    assign t = {rem_reg, q_reg[MAG_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == STEP_W'(MAG_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (start) begin
            step_reg <= '0;
            neg_reg  <= index[PIDX_W-1];
            q_reg    <= index[PIDX_W-1] ? -{index[PIDX_W-1], index}
                                        : {index[PIDX_W-1], index};
            rem_reg  <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            q_reg    <= {q_reg[MAG_W-2:0], 1'b0};
            if (t >= {1'b0, count}) begin
                rem_reg <= CNT_W'(t - {1'b0, count});
            end else begin
                rem_reg <= t[CNT_W-1:0];
            end
        end
    end

    // Remainder is taken toward zero, so a negative index folds back from the count.
    assign w       = (neg_reg && rem_reg != '0) ? count - rem_reg : rem_reg;
    assign done    = done_reg;
    assign wrapped = w[IDX_W-1:0];

endmodule
